// ----- sv/conv5_pkg.sv -----
`timescale 1ns / 1ps

package conv5_pkg;

  // Line store geometry
  localparam int MaxWidth  = 1024;
  localparam int ColW      = $clog2(MaxWidth);   // column index bits
  localparam int FillW     = ColW + 1;           // can hold MaxWidth itself
  localparam int LineRows  = 4;
  localparam int KernDim   = 5;
  localparam int KernTaps  = KernDim * KernDim;
  localparam int MinDim    = 5;

  // Field widths
  localparam int PixW      = 16;
  localparam int CoefW     = 12;
  localparam int ProdW     = PixW + CoefW;       // 28
  localparam int RowSumW   = ProdW + 3;          // sum of five products
  localparam int SumW      = 32;                 // sum of 25 products
  localparam int WidthW    = 11;
  localparam int HeightW   = 16;
  localparam int KrowW     = KernDim * CoefW;    // 60
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = KrowW;
  localparam int MemW      = LineRows * PixW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgKernRow0    = 3'd2,
    CfgKernRow1    = 3'd3,
    CfgKernRow2    = 3'd4,
    CfgKernRow3    = 3'd5,
    CfgKernRow4    = 3'd6
  } cfg_reg_e;

  typedef logic signed [PixW-1:0]    pix_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [RowSumW-1:0] row_sum_t;
  typedef logic signed [SumW-1:0]    sum_t;

endpackage

// ----- sv/conv2d_5x5_stream.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Payload (low bit up)              Accepted when
// s_axis    in   tdata[15:0] pixel (signed)        s_axis_tvalid & s_axis_tready
// m_axis    out  tdata[31:0] window_sum (signed),  m_axis_tvalid & m_axis_tready
//                tlast frame_done
// cfg       in   cfg_idx_i register, cfg_data_i     cfg_we_i
//
// One pixel per clock sustained while the output accepts. The line store
// is a single-port-write, single-read 1024 x 64 RAM (four rows packed per
// column); each pixel does one read at its column on acceptance and one
// write-back one stage later. A result passes in turn through the stage 1,
// product, row-sum and output registers. Reset is asynchronous, active
// low; there is no clearing pass: a fill counter marks the column prefix
// written since reset, and unwritten columns read as zero. Output stalls
// back up stage by stage: up to three more result-producing pixels are
// taken while a result waits, and the input stops only when stage 1, the
// product and row-sum stages and the output register are all full.

module conv2d_5x5_stream import conv5_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel in: [15:0] pixel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,
  // result out: [31:0] window_sum
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SumW-1:0]     m_axis_tdata,
  output logic                m_axis_tlast,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [KrowW-1:0]   krow_q [KernDim];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(MaxWidth);
      height_q <= HeightW'(MinDim);
      for (int i = 0; i < KernDim; i++) krow_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgImageWidth:  width_q   <= cfg_data_i[WidthW-1:0];
        CfgImageHeight: height_q  <= cfg_data_i[HeightW-1:0];
        CfgKernRow0:    krow_q[0] <= cfg_data_i;
        CfgKernRow1:    krow_q[1] <= cfg_data_i;
        CfgKernRow2:    krow_q[2] <= cfg_data_i;
        CfgKernRow3:    krow_q[3] <= cfg_data_i;
        CfgKernRow4:    krow_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size: width clamped to [5, MaxWidth], height at least 5
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;

  always_comb begin
    if (width_q < WidthW'(MinDim))         w_eff = WidthW'(MinDim);
    else if (width_q > WidthW'(MaxWidth))  w_eff = WidthW'(MaxWidth);
    else                                   w_eff = width_q;
    h_eff = (height_q < HeightW'(MinDim)) ? HeightW'(MinDim) : height_q;
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage moves when the next one is empty or moving
  // ---------------------------------------------------------------------------
  logic s1_v_q, p_v_q, a1_v_q, o_v_q;
  logic en_o, en_a1, en_p, en_s1;
  logic s_acc;

  assign en_o          = !o_v_q  || m_axis_tready;
  assign en_a1         = !a1_v_q || en_o;
  assign en_p          = !p_v_q  || en_a1;
  assign en_s1         = !s1_v_q || en_p;
  assign s_axis_tready = en_s1;
  assign s_acc         = s_axis_tvalid && en_s1;

  // ---------------------------------------------------------------------------
  // Raster counters and fill mark
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]    col_q;
  logic [HeightW-1:0] row_q;
  logic [FillW-1:0]   fill_q;
  logic               last_col, last_row, emit, col_hit;

  assign last_col = {1'b0, col_q} >= (w_eff - WidthW'(1));
  assign last_row = row_q >= (h_eff - HeightW'(1));
  assign emit     = (row_q >= HeightW'(KernDim - 1)) && (col_q >= ColW'(KernDim - 1));
  assign col_hit  = {1'b0, col_q} < fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      fill_q <= '0;
    end else if (s_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + HeightW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
      // columns are visited in order from 0, so the written set is a prefix
      if (!col_hit) fill_q <= {1'b0, col_q} + FillW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: slot k holds row r-4+k of that column
  // ---------------------------------------------------------------------------
  logic [MemW-1:0] line_mem [MaxWidth];
  logic [MemW-1:0] rdata_q;
  logic [MemW-1:0] wdata;
  logic            mem_we;

  // Stage 1 payload
  logic [ColW-1:0] s1_col_q;
  pix_t            s1_pix_q;
  logic            s1_hit_q, s1_emit_q, s1_last_q;

  always_ff @(posedge clk_i) begin
    if (s_acc)  rdata_q <= line_mem[col_q];
    if (mem_we) line_mem[s1_col_q] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_s1) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_col_q  <= col_q;
      s1_pix_q  <= pix_t'(s_axis_tdata);
      s1_hit_q  <= col_hit;
      s1_emit_q <= emit;
      s1_last_q <= last_col && last_row;
    end
  end

  // Stage 1 retires: write back the shifted column, slide the window,
  // multiply the new window by the coefficients.
  logic s1_go;
  pix_t col_v [KernDim];
  pix_t win_q [KernDim][KernDim];
  pix_t win_d [KernDim][KernDim];

  assign s1_go  = s1_v_q && en_p;
  assign mem_we = s1_go;

  always_comb begin
    for (int k = 0; k < LineRows; k++) begin
      col_v[k] = s1_hit_q ? pix_t'(rdata_q[k*PixW +: PixW]) : '0;
    end
    col_v[KernDim-1] = s1_pix_q;
    for (int k = 0; k < LineRows; k++) begin
      wdata[k*PixW +: PixW] = col_v[k+1];
    end
    for (int r = 0; r < KernDim; r++) begin
      for (int c = 0; c < KernDim - 1; c++) win_d[r][c] = win_q[r][c+1];
      win_d[r][KernDim-1] = col_v[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KernDim; r++)
        for (int c = 0; c < KernDim; c++) win_q[r][c] <= '0;
    end else if (s1_go) begin
      win_q <= win_d;
    end
  end

  // Products
  prod_t prod_d [KernTaps];
  prod_t prod_q [KernTaps];
  logic  p_last_q;

  always_comb begin
    logic signed [CoefW-1:0] cf;
    for (int r = 0; r < KernDim; r++) begin
      for (int c = 0; c < KernDim; c++) begin
        cf = krow_q[r][c*CoefW +: CoefW];
        prod_d[r*KernDim + c] = win_d[r][c] * cf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en_p) begin
      p_v_q <= s1_v_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      prod_q   <= prod_d;
      p_last_q <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Adder tree: five row sums, then the total in the output register
  // ---------------------------------------------------------------------------
  row_sum_t rs_d [KernDim];
  row_sum_t rs_q [KernDim];
  logic     a1_last_q;
  sum_t     sum_d, o_sum_q;
  logic     o_last_q;

  always_comb begin
    for (int r = 0; r < KernDim; r++) begin
      rs_d[r] = '0;
      for (int c = 0; c < KernDim; c++) begin
        rs_d[r] = rs_d[r] + RowSumW'(prod_q[r*KernDim + c]);
      end
    end
    sum_d = '0;
    for (int r = 0; r < KernDim; r++) sum_d = sum_d + SumW'(rs_q[r]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (en_a1) a1_v_q <= p_v_q;
      if (en_o)  o_v_q  <= a1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_v_q && en_a1) begin
      rs_q      <= rs_d;
      a1_last_q <= p_last_q;
    end
    if (a1_v_q && en_o) begin
      o_sum_q  <= sum_d;
      o_last_q <= a1_last_q;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = o_sum_q;
  assign m_axis_tlast  = o_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // write-back never hits the column being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && s_acc) |-> (s1_col_q != col_q))
    else $error("line store read and write at same column");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MaxWidth))
    else $error("fill mark beyond line store depth");

  // input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_v_q && p_v_q && a1_v_q && o_v_q && !m_axis_tready))
    else $error("input stalled with a bubble in the pipeline");

  // a retiring stage 1 item that emits must arrive valid in the product stage
  a_win_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_emit_q) |=> p_v_q)
    else $error("emitting item lost after stage 1");

endmodule
